// ===== rtl/isvm_pkg.sv =====
// isvm_pkg: opcodes, status codes, sequencer states and unit command types
// for the integer stack machine executor; no dependencies
`default_nettype none
package isvm_pkg;
   localparam logic [7:0] OP_HALT  = 8'd0;
   localparam logic [7:0] OP_ADD   = 8'd1;
   localparam logic [7:0] OP_SUB   = 8'd2;
   localparam logic [7:0] OP_MUL   = 8'd3;
   localparam logic [7:0] OP_DIV   = 8'd4;
   localparam logic [7:0] OP_NEG   = 8'd5;
   localparam logic [7:0] OP_PRINT = 8'd6;
   localparam logic [7:0] OP_POP   = 8'd7;
   localparam logic [7:0] OP_CONST = 8'd8;
   localparam logic [7:0] OP_LOAD  = 8'd9;
   localparam logic [7:0] OP_STORE = 8'd10;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_HALT   = 3'd1;
   localparam logic [2:0] ST_BADOP  = 3'd2;
   localparam logic [2:0] ST_UNDER  = 3'd3;
   localparam logic [2:0] ST_OVER   = 3'd4;
   localparam logic [2:0] ST_DIVZ   = 3'd5;
   localparam logic [2:0] ST_BADLOC = 3'd6;

   typedef enum logic [2:0] {
      ALU_ADD = 3'd0,
      ALU_SUB = 3'd1,
      ALU_MUL = 3'd2,
      ALU_DIV = 3'd3,
      ALU_NEG = 3'd4
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } alu_rsp_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RDB   = 8'b0000_0010,
      S_RDA   = 8'b0000_0100,
      S_LDLOC = 8'b0000_1000,
      S_EXEC  = 8'b0001_0000,
      S_WAIT  = 8'b0010_0000,
      S_WRITE = 8'b0100_0000,
      S_RESP  = 8'b1000_0000
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/integer_stack_vm_executor.sv =====
// integer_stack_vm_executor: top level, sequencer, operand stack and local
// store memories; uses isvm_pkg and isvm_alu
`default_nettype none
// channel | ports                                         | direction
// req     | req_valid req_stall req_mode req_local_slot   | in
//         | req_const_value                               |
// rsp     | rsp_valid rsp_stall rsp_status rsp_print_*    | out
//         | rsp_stack_level                               |
// an item runs from S_RDB to S_RESP: halt, pop and early errors directly,
// const via S_WRITE, load via S_LDLOC and S_WRITE, print and store via
// S_EXEC, negate via S_EXEC and S_WAIT, add, sub, mul and div via S_RDA,
// S_EXEC and S_WAIT, mul and div waiting longer in the shared alu; the
// single stack read port reads the two operands in turn, in S_RDB and S_RDA
// after reset a clearing pass zeroes the local store with req_stall high
// req_stall is high whenever an item is in flight; a waiting result holds
// the next item in its last step until rsp_stall drops
module integer_stack_vm_executor #(
   parameter int STACK_DEPTH = 64,
   parameter int LOCAL_COUNT = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_mode,
   input  wire logic [23:0] req_local_slot,
   input  wire logic signed [31:0] req_const_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic             rsp_print_valid,
   output logic signed [31:0] rsp_print_value,
   output logic [6:0]       rsp_stack_level
);
   import isvm_pkg::*;

   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SCW = $clog2(STACK_DEPTH + 1);
   localparam int LAW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
   localparam int LCW = $clog2(LOCAL_COUNT + 1);

   // memories
   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] local_mem [LOCAL_COUNT];

   state_type   state_ff, state_in;
   logic [SCW-1:0] count_ff, count_in;
   logic        run_ff, run_in;
   logic        clr_ff, clr_in;
   logic [LCW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [7:0]  op_ff, op_in;
   logic [23:0] slot_ff, slot_in;
   logic [31:0] cval_ff, cval_in;
   logic [31:0] opb_ff, opb_in;
   logic [31:0] wdata_ff, wdata_in;
   logic [2:0]  st_ff, st_in;
   logic        pv_ff, pv_in;
   logic [31:0] pval_ff, pval_in;
   logic        rv_ff, rv_in;

   // memory port controls
   logic           s_rd;
   logic [SAW-1:0] s_raddr;
   logic [31:0]    s_rdata;
   logic           s_we;
   logic [SAW-1:0] s_waddr;
   logic           l_rd;
   logic [31:0]    l_rdata;
   logic           l_we;
   logic [LAW-1:0] l_waddr;
   logic [31:0]    l_wdata;

   alu_cmd_type alu_cmd;
   alu_rsp_type alu_rsp;
   alu_op_type  alu_sel;

   logic        slot_ok;
   logic [SCW-1:0] cnt_eff;
   logic        accept;

   isvm_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .a     (s_rdata),
      .b     (opb_ff),
      .rsp   (alu_rsp)
   );

   assign accept = req_valid && !req_stall;
   assign req_stall = !(state_ff == S_IDLE) || clr_ff;
   assign slot_ok = ({8'd0, slot_ff} < 32'(LOCAL_COUNT));
   // the stack is emptied at the start of a run
   assign cnt_eff = count_ff;

   always_comb begin
      case (op_ff)
         OP_ADD:  alu_sel = ALU_ADD;
         OP_SUB:  alu_sel = ALU_SUB;
         OP_MUL:  alu_sel = ALU_MUL;
         OP_DIV:  alu_sel = ALU_DIV;
         default: alu_sel = ALU_NEG;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      run_in = run_ff;
      clr_in = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      op_in = op_ff;
      slot_in = slot_ff;
      cval_in = cval_ff;
      opb_in = opb_ff;
      wdata_in = wdata_ff;
      st_in = st_ff;
      pv_in = pv_ff;
      pval_in = pval_ff;
      rv_in = rv_ff;
      s_rd = 1'b0;
      s_raddr = '0;
      s_we = 1'b0;
      s_waddr = '0;
      l_rd = 1'b0;
      l_we = 1'b0;
      l_waddr = clr_cnt_ff[LAW-1:0];
      l_wdata = 32'd0;
      alu_cmd.start = 1'b0;
      alu_cmd.op = alu_sel;

      // clearing pass over the local store
      if (clr_ff) begin
         l_we = 1'b1;
         clr_cnt_in = clr_cnt_ff + LCW'(1);
         if (clr_cnt_ff == LCW'(LOCAL_COUNT - 1)) begin
            clr_in = 1'b0;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in = req_mode;
               slot_in = req_local_slot;
               cval_in = req_const_value;
               st_in = ST_OK;
               pv_in = 1'b0;
               pval_in = 32'd0;
               if (!run_ff) begin
                  count_in = '0;
                  run_in = 1'b1;
               end
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            // decode and error checks, read top of stack
            state_in = S_RESP;
            case (op_ff)
               OP_HALT: st_in = ST_HALT;
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  if (cnt_eff < SCW'(2)) begin
                     st_in = ST_UNDER;
                  end else begin
                     s_rd = 1'b1;
                     s_raddr = SAW'(cnt_eff - SCW'(1));
                     state_in = S_RDA;
                  end
               end
               OP_NEG, OP_PRINT, OP_POP: begin
                  if (cnt_eff == '0) begin
                     st_in = ST_UNDER;
                  end else if (op_ff == OP_POP) begin
                     count_in = cnt_eff - SCW'(1);
                  end else begin
                     s_rd = 1'b1;
                     s_raddr = SAW'(cnt_eff - SCW'(1));
                     state_in = S_EXEC;
                  end
               end
               OP_CONST: begin
                  if (cnt_eff >= SCW'(STACK_DEPTH)) begin
                     st_in = ST_OVER;
                  end else begin
                     wdata_in = cval_ff;
                     state_in = S_WRITE;
                  end
               end
               OP_LOAD: begin
                  if (!slot_ok) begin
                     st_in = ST_BADLOC;
                  end else if (cnt_eff >= SCW'(STACK_DEPTH)) begin
                     st_in = ST_OVER;
                  end else begin
                     l_rd = 1'b1;
                     state_in = S_LDLOC;
                  end
               end
               OP_STORE: begin
                  if (cnt_eff == '0) begin
                     st_in = ST_UNDER;
                  end else if (!slot_ok) begin
                     st_in = ST_BADLOC;
                  end else begin
                     s_rd = 1'b1;
                     s_raddr = SAW'(cnt_eff - SCW'(1));
                     state_in = S_EXEC;
                  end
               end
               default: st_in = ST_BADOP;
            endcase
         end
         S_RDA: begin
            // b arrived, read a
            opb_in = s_rdata;
            s_rd = 1'b1;
            s_raddr = SAW'(cnt_eff - SCW'(2));
            state_in = S_EXEC;
         end
         S_LDLOC: begin
            wdata_in = l_rdata;
            state_in = S_WRITE;
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (op_ff)
               OP_PRINT: begin
                  count_in = cnt_eff - SCW'(1);
                  pv_in = 1'b1;
                  pval_in = s_rdata;
               end
               OP_STORE: begin
                  count_in = cnt_eff - SCW'(1);
                  l_we = 1'b1;
                  l_waddr = slot_ff[LAW-1:0];
                  l_wdata = s_rdata;
               end
               OP_DIV: begin
                  if (opb_ff == 32'd0) begin
                     st_in = ST_DIVZ;
                  end else begin
                     alu_cmd.start = 1'b1;
                     state_in = S_WAIT;
                  end
               end
               default: begin
                  alu_cmd.start = 1'b1;
                  state_in = S_WAIT;
               end
            endcase
         end
         S_WAIT: begin
            if (alu_rsp.done) begin
               s_we = 1'b1;
               if (op_ff == OP_NEG) begin
                  s_waddr = SAW'(cnt_eff - SCW'(1));
               end else begin
                  s_waddr = SAW'(cnt_eff - SCW'(2));
                  count_in = cnt_eff - SCW'(1);
               end
               state_in = S_RESP;
            end
         end
         S_WRITE: begin
            s_we = 1'b1;
            s_waddr = SAW'(cnt_eff);
            count_in = cnt_eff + SCW'(1);
            state_in = S_RESP;
         end
         S_RESP: begin
            // load the result register once the previous result has drained
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               if (st_ff != ST_OK) begin
                  run_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (rv_ff && !rsp_stall && !(state_ff == S_RESP)) begin
         rv_in = 1'b0;
      end
   end

   // output register, loaded on entry to the idle state
   logic [2:0]  ost_ff;
   logic        opv_ff;
   logic [31:0] opval_ff;
   logic [6:0]  olvl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         run_ff <= 1'b0;
         clr_ff <= 1'b1;
         clr_cnt_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         run_ff <= run_in;
         clr_ff <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         rv_ff <= rv_in;
      end
      op_ff <= op_in;
      slot_ff <= slot_in;
      cval_ff <= cval_in;
      opb_ff <= opb_in;
      wdata_ff <= wdata_in;
      st_ff <= st_in;
      pv_ff <= pv_in;
      pval_ff <= pval_in;
      if (state_ff == S_RESP && (!rv_ff || !rsp_stall)) begin
         ost_ff <= st_ff;
         opv_ff <= pv_ff;
         opval_ff <= pval_ff;
         olvl_ff <= 7'(count_ff);
      end
   end

   // stack memory, one read and one write port
   always_ff @(posedge clock) begin
      if (s_we) begin
         stack_mem[s_waddr] <= (state_ff == S_WRITE) ? wdata_ff : alu_rsp.result;
      end
      if (s_rd) begin
         s_rdata <= stack_mem[s_raddr];
      end
   end

   // local store memory
   always_ff @(posedge clock) begin
      if (l_we) begin
         local_mem[l_waddr] <= l_wdata;
      end
      if (l_rd) begin
         l_rdata <= local_mem[slot_ff[LAW-1:0]];
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = ost_ff;
   assign rsp_print_valid = opv_ff;
   assign rsp_print_value = opval_ff;
   assign rsp_stack_level = olvl_ff;

`ifndef SYNTHESIS
   // stack count never exceeds the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SCW'(STACK_DEPTH))
      else $error("stack count out of range");
   // no item is taken during the clearing pass
   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> req_stall)
      else $error("accept during local clear");
   // a stalled result holds its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status)))
      else $error("result dropped while stalled");
   // an accepted item leaves the idle state
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RDB))
      else $error("accept did not start the sequencer");
`endif
endmodule
`default_nettype wire

// ===== rtl/isvm_alu.sv =====
// isvm_alu: shared arithmetic unit, add/sub/negate registered on the start
// command, multiply in two 16-bit halves, divide one quotient bit a cycle; uses isvm_pkg
`default_nettype none
module isvm_alu (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire isvm_pkg::alu_cmd_type cmd,
   input  wire logic [31:0]        a,
   input  wire logic [31:0]        b,
   output isvm_pkg::alu_rsp_type   rsp
);
   import isvm_pkg::*;

   logic        busy_ff, busy_in;
   alu_op_type  op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [31:0] opa_ff, opa_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [31:0] res_ff, res_in;
   logic [32:0] trial;
   logic [31:0] shifted;
   logic [31:0] prod;

   assign shifted = {rem_ff[30:0], quo_ff[31]};
   assign trial = {1'b0, shifted} - {1'b0, dvs_ff};
   assign prod = opa_ff * {16'd0, (cnt_ff[0] ? dvs_ff[31:16] : dvs_ff[15:0])};

   always_comb begin
      busy_in = busy_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      opa_in = opa_ff;
      neg_in = neg_ff;
      done_in = 1'b0;
      res_in = res_ff;
      if (cmd.start) begin
         op_in = cmd.op;
         cnt_in = 6'd0;
         case (cmd.op)
            ALU_ADD: begin
               res_in = a + b;
               done_in = 1'b1;
            end
            ALU_SUB: begin
               res_in = a - b;
               done_in = 1'b1;
            end
            ALU_NEG: begin
               res_in = 32'd0 - a;
               done_in = 1'b1;
            end
            ALU_MUL: begin
               busy_in = 1'b1;
               opa_in = a;
               dvs_in = b;
               acc_in = 32'd0;
            end
            ALU_DIV: begin
               busy_in = 1'b1;
               quo_in = a[31] ? 32'd0 - a : a;
               dvs_in = b[31] ? 32'd0 - b : b;
               rem_in = 32'd0;
               neg_in = a[31] ^ b[31];
            end
            default: begin
               res_in = a;
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 6'd1;
         if (op_ff == ALU_MUL) begin
            // low half first, then high half shifted by 16
            if (!cnt_ff[0]) begin
               acc_in = prod;
            end else begin
               res_in = acc_ff + {prod[15:0], 16'd0};
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end else begin
            // restoring divide, one quotient bit a cycle
            if (!trial[32]) begin
               rem_in = trial[31:0];
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            if (cnt_ff == 6'd31) begin
               res_in = neg_ff ? 32'd0 - quo_in : quo_in;
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      opa_ff <= opa_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign rsp.done = done_ff;
   assign rsp.result = res_ff;
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// tb: self-checking testbench for integer_stack_vm_executor, with a stack
// machine predictor in a scoreboard class; depends on isvm_pkg and the rtl
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import isvm_pkg::*;

   localparam int STACK_DEPTH = 64;
   localparam int LOCAL_COUNT = 256;
   localparam int CYCLE_LIMIT = 400000;

   // one predicted result item
   typedef struct {
      logic [2:0]  status;
      logic        print_valid;
      logic [31:0] print_value;
      logic [6:0]  stack_level;
   } vm_result_type;

   // predictor of the executor and the queue of results it owes
   class vm_scoreboard;
      logic [31:0] stack_mem [STACK_DEPTH];
      int unsigned depth;
      logic [31:0] locals [LOCAL_COUNT];
      bit running;
      vm_result_type owed_results [$];
      int error_count;

      function new();
         depth = 0;
         running = 0;
         error_count = 0;
         foreach (locals[i]) locals[i] = '0;
         foreach (stack_mem[i]) stack_mem[i] = '0;
      endfunction

      function logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
         logic [31:0] ma, mb, q;
         ma = a[31] ? -a : a;
         mb = b[31] ? -b : b;
         q = ma / mb;
         return (a[31] != b[31]) ? -q : q;
      endfunction

      // execute one instruction on the shadow state
      function void note_instruction(logic [7:0] mode, logic [23:0] slot,
                                     logic [31:0] cval);
         vm_result_type r;
         logic [31:0] a, b, v;
         r.status = ST_OK;
         r.print_valid = 0;
         r.print_value = '0;
         if (!running) begin
            depth = 0;
            running = 1;
         end
         case (mode)
            OP_HALT: r.status = ST_HALT;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (depth < 2) r.status = ST_UNDER;
               else begin
                  b = stack_mem[depth-1];
                  a = stack_mem[depth-2];
                  if (mode == OP_DIV && b == 0) r.status = ST_DIVZ;
                  else begin
                     case (mode)
                        OP_ADD: v = a + b;
                        OP_SUB: v = a - b;
                        OP_MUL: v = a * b;
                        default: v = div_trunc(a, b);
                     endcase
                     depth--;
                     stack_mem[depth-1] = v;
                  end
               end
            end
            OP_NEG: begin
               if (depth < 1) r.status = ST_UNDER;
               else stack_mem[depth-1] = -stack_mem[depth-1];
            end
            OP_PRINT, OP_POP: begin
               if (depth < 1) r.status = ST_UNDER;
               else begin
                  depth--;
                  if (mode == OP_PRINT) begin
                     r.print_valid = 1;
                     r.print_value = stack_mem[depth];
                  end
               end
            end
            OP_CONST: begin
               if (depth >= STACK_DEPTH) r.status = ST_OVER;
               else stack_mem[depth++] = cval;
            end
            OP_LOAD: begin
               if (slot >= LOCAL_COUNT) r.status = ST_BADLOC;
               else if (depth >= STACK_DEPTH) r.status = ST_OVER;
               else stack_mem[depth++] = locals[slot];
            end
            OP_STORE: begin
               if (depth < 1) r.status = ST_UNDER;
               else if (slot >= LOCAL_COUNT) r.status = ST_BADLOC;
               else begin
                  depth--;
                  locals[slot] = stack_mem[depth];
               end
            end
            default: r.status = ST_BADOP;
         endcase
         if (r.status != ST_OK) running = 0;
         r.stack_level = depth[6:0];
         owed_results.push_back(r);
      endfunction

      function void check_result(logic [2:0] st, logic pv, logic [31:0] pval,
                                 logic [6:0] lvl);
         vm_result_type e;
         if (owed_results.size() == 0) begin
            $error("result item with none expected");
            error_count++;
            return;
         end
         e = owed_results.pop_front();
         if (st !== e.status) begin
            $error("status expected %0d actual %0d", e.status, st);
            error_count++;
         end
         if (pv !== e.print_valid) begin
            $error("print_valid expected %0d actual %0d", e.print_valid, pv);
            error_count++;
         end
         if (pval !== e.print_value) begin
            $error("print_value expected %h actual %h", e.print_value, pval);
            error_count++;
         end
         if (lvl !== e.stack_level) begin
            $error("stack_level expected %0d actual %0d", e.stack_level, lvl);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [7:0] req_mode = '0;
   logic [23:0] req_local_slot = '0;
   logic signed [31:0] req_const_value = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_status;
   logic rsp_print_valid;
   logic signed [31:0] rsp_print_value;
   logic [6:0] rsp_stack_level;

   vm_scoreboard board = new();
   int cycle_count = 0;
   // idling is switched off for a stretch in the middle of the random part
   bit idle_enable = 1;

   always #6 clock = ~clock;

   integer_stack_vm_executor #(.STACK_DEPTH(STACK_DEPTH), .LOCAL_COUNT(LOCAL_COUNT)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_local_slot(req_local_slot), .req_const_value(req_const_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_print_valid(rsp_print_valid), .rsp_print_value(rsp_print_value),
      .rsp_stack_level(rsp_stack_level)
   );

   // cycle counter guards against a hung block
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   // receiver: random stall, result checked when it is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result(rsp_status, rsp_print_valid, rsp_print_value,
                            rsp_stack_level);
      rsp_stall <= idle_enable && ($urandom_range(99) < 20);
   end

   // present one item and hold it until taken; gaps go in front of it,
   // valid stays high into the next item when there is no gap
   task automatic send_instruction(logic [7:0] mode, logic [23:0] slot,
                                   logic [31:0] cval);
      while (idle_enable && $urandom_range(99) < 20) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= mode;
      req_local_slot <= slot;
      req_const_value <= cval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_instruction(mode, slot, cval);
   endtask

   task automatic drain_results();
      req_valid <= 0;
      while (board.owed_results.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed arithmetic, with stack and local traffic
   task automatic send_random_instruction();
      int pick;
      logic [31:0] v;
      logic [23:0] slot;
      pick = $urandom_range(99);
      v = $urandom();
      case ($urandom_range(3))
         0: v = $urandom_range(15) - 8;
         1: v = {$urandom_range(1), 31'h0} | $urandom_range(3);
         default: ;
      endcase
      slot = ($urandom_range(9) == 0) ? 24'($urandom()) : 24'($urandom_range(LOCAL_COUNT - 1));
      if (pick < 30) send_instruction(OP_CONST, slot, v);
      else if (pick < 55) send_instruction(8'($urandom_range(OP_ADD, OP_DIV)), slot, v);
      else if (pick < 62) send_instruction(OP_NEG, slot, v);
      else if (pick < 70) send_instruction(OP_PRINT, slot, v);
      else if (pick < 74) send_instruction(OP_POP, slot, v);
      else if (pick < 84) send_instruction(OP_LOAD, slot, v);
      else if (pick < 94) send_instruction(OP_STORE, slot, v);
      else if (pick < 97) send_instruction(OP_HALT, slot, v);
      else send_instruction(8'($urandom_range(255, 11)), slot, v);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: underflow on empty stack, extremes, div corners
      send_instruction(OP_ADD, 0, 0);
      send_instruction(OP_CONST, 0, 32'h8000_0000);
      send_instruction(OP_CONST, 0, 32'hFFFF_FFFF);
      send_instruction(OP_DIV, 0, 0);              // min / -1
      send_instruction(OP_CONST, 0, 32'h7FFF_FFFF);
      send_instruction(OP_MUL, 0, 0);
      send_instruction(OP_CONST, 0, -7);
      send_instruction(OP_CONST, 0, 2);
      send_instruction(OP_DIV, 0, 0);              // truncation toward zero
      send_instruction(OP_NEG, 0, 0);
      send_instruction(OP_SUB, 0, 0);
      send_instruction(OP_STORE, 24'hFF, 0);
      send_instruction(OP_LOAD, 24'hFF, 0);
      send_instruction(OP_LOAD, 24'hFFFFFF, 0);    // bad local on load
      send_instruction(OP_CONST, 0, 5);            // new run clears the stack
      send_instruction(OP_STORE, 24'h100, 0);      // bad local on store
      send_instruction(OP_CONST, 0, 0);
      send_instruction(OP_CONST, 0, 0);
      send_instruction(OP_DIV, 0, 0);              // divide by zero
      send_instruction(OP_CONST, 0, 9);
      send_instruction(OP_PRINT, 0, 0);
      send_instruction(OP_POP, 0, 0);
      send_instruction(8'hFF, 0, 0);
      send_instruction(OP_HALT, 0, 0);
      // fill the stack to overflow, then load onto a full stack
      for (int i = 0; i <= STACK_DEPTH; i++) send_instruction(OP_CONST, 0, $urandom());
      for (int i = 0; i < STACK_DEPTH; i++) send_instruction(OP_CONST, 0, i);
      send_instruction(OP_LOAD, 3, 0);
      drain_results();

      // random part, with a quiet stretch and a full drain midway
      for (int n = 0; n < 300; n++) begin
         idle_enable = !(n >= 100 && n < 180);
         if (n == 200) drain_results();
         send_random_instruction();
      end
      idle_enable = 1;

      drain_results();
      repeat (80) @(posedge clock);
      if (board.error_count == 0 && board.owed_results.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/isvm_pkg.sv
rtl/isvm_alu.sv
rtl/integer_stack_vm_executor.sv
verif/tb.sv
